### design/bsg_pkg.sv
// ----------------------------------------------------------------------------
// bsg_pkg: shared types and constants for the bounding sphere grow block
// Field structs, the sequencer states, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package bsg_pkg;

   // field and datapath widths
   localparam int CoordWidth   = 32;
   localparam int RadWidth     = CoordWidth - 1;
   localparam int DiffWidth    = CoordWidth + 1;
   localparam int MulWidth     = CoordWidth + 2;
   localparam int ProdWidth    = 2 * MulWidth;
   localparam int SqWidth      = 2 * DiffWidth;
   localparam int RootWidth    = DiffWidth;
   localparam int QuoWidth     = CoordWidth;
   localparam int StepCntWidth = 6;
   localparam int CsrIdxWidth  = 2;

   // bit-serial step counts (last step index)
   localparam int MulLast  = MulWidth - 1;
   localparam int RootLast = RootWidth - 1;
   localparam int DivLast  = QuoWidth - 1;

   // largest radius
   localparam logic [RadWidth-1:0] RadMax = '1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQ_GO,
      ST_SQ,
      ST_SUM1,
      ST_SUM2,
      ST_CMP,
      ST_ROOT_GO,
      ST_ROOT,
      ST_MUL_GO,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_UPD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] point_z;
      logic                         restart;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] center_x_out;
      logic signed [CoordWidth-1:0] center_y_out;
      logic signed [CoordWidth-1:0] center_z_out;
      logic        [RadWidth-1:0]   radius_out;
      logic                         grew;
   } rsp_type;

endpackage

### design/bsg_mul.sv
// ----------------------------------------------------------------------------
// bsg_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle, narrow adder; done pulses once.
// ----------------------------------------------------------------------------
module bsg_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bsg_pkg::MulWidth-1:0]         mcand,
   input  logic [bsg_pkg::MulWidth-1:0]         mplier,
   output logic                                 done,
   output logic [bsg_pkg::ProdWidth-1:0]        prod
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [bsg_pkg::StepCntWidth-1:0]     cnt_ff, cnt_in;
   logic [bsg_pkg::MulWidth-1:0]         mcand_ff;
   logic [bsg_pkg::MulWidth-1:0]         hi_ff;
   logic [bsg_pkg::MulWidth-1:0]         lo_ff;
   logic [bsg_pkg::MulWidth:0]           sum;
   logic                                 last;

   // partial sum of the upper half
   assign sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   assign last = (cnt_ff == bsg_pkg::StepCntWidth'(bsg_pkg::MulLast));

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // product shifts right one bit a step
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         hi_ff    <= '0;
         lo_ff    <= mplier;
      end else if (busy_ff) begin
         hi_ff <= sum[bsg_pkg::MulWidth:1];
         lo_ff <= {sum[0], lo_ff[bsg_pkg::MulWidth-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

### design/bsg_sqrt.sv
// ----------------------------------------------------------------------------
// bsg_sqrt: digit-serial integer square root
// Restoring method, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module bsg_sqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bsg_pkg::SqWidth-1:0]          radicand,
   output logic                                 done,
   output logic [bsg_pkg::RootWidth-1:0]        root
);

   localparam int RemWidth = bsg_pkg::RootWidth + 2;

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [bsg_pkg::StepCntWidth-1:0]     cnt_ff, cnt_in;
   logic [bsg_pkg::SqWidth-1:0]          rad_ff;
   logic [RemWidth-1:0]                  rem_ff;
   logic [bsg_pkg::RootWidth-1:0]        root_ff;
   logic [RemWidth+1:0]                  trem;
   logic [RemWidth+1:0]                  trial;
   logic                                 fits;
   logic                                 last;

   assign trem  = {rem_ff, rad_ff[bsg_pkg::SqWidth-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign fits  = (trem >= trial);
   assign last  = (cnt_ff == bsg_pkg::StepCntWidth'(bsg_pkg::RootLast));

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // one root digit per step
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[bsg_pkg::SqWidth-3:0], 2'b00};
         rem_ff  <= fits ? RemWidth'(trem - trial) : RemWidth'(trem);
         root_ff <= {root_ff[bsg_pkg::RootWidth-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### design/bsg_div.sv
// ----------------------------------------------------------------------------
// bsg_div: bit-serial restoring divider
// One quotient bit per cycle; the quotient is known to fit QuoWidth bits.
// ----------------------------------------------------------------------------
module bsg_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bsg_pkg::ProdWidth-1:0]        dividend,
   input  logic [bsg_pkg::MulWidth-1:0]         divisor,
   output logic                                 done,
   output logic [bsg_pkg::QuoWidth-1:0]         quot
);

   localparam int RemWidth = bsg_pkg::MulWidth;
   localparam int LowWidth = bsg_pkg::QuoWidth;

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [bsg_pkg::StepCntWidth-1:0]     cnt_ff, cnt_in;
   logic [RemWidth-1:0]                  dv_ff;
   logic [RemWidth-1:0]                  rem_ff;
   logic [LowWidth-1:0]                  low_ff;
   logic [RemWidth:0]                    trem;
   logic                                 ge;
   logic                                 last;

   assign trem = {rem_ff, low_ff[LowWidth-1]};
   assign ge   = (trem >= {1'b0, dv_ff});
   assign last = (cnt_ff == bsg_pkg::StepCntWidth'(bsg_pkg::DivLast));

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // upper dividend bits start below the divisor; quotient bits shift in low
   always_ff @(posedge clock) begin
      if (start) begin
         dv_ff  <= divisor;
         rem_ff <= dividend[LowWidth +: RemWidth];
         low_ff <= dividend[LowWidth-1:0];
      end else if (busy_ff) begin
         rem_ff <= ge ? RemWidth'(trem - {1'b0, dv_ff}) : trem[RemWidth-1:0];
         low_ff <= {low_ff[LowWidth-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = low_ff;

endmodule

### design/bounding_sphere_grow_top.sv
// ----------------------------------------------------------------------------
// bounding_sphere_grow_top: grows a bounding sphere around a point stream
// Sequencer plus bit-serial multipliers, square root and dividers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_stall   req_data  (bsg_pkg::req_type)
//  rsp_      out        rsp_valid / rsp_stall   rsp_data  (bsg_pkg::rsp_type)
//  csr_      in         csr_we                  csr_index, csr_wdata
//
//  A point outside the sphere runs the bit-serial multiply, square root,
//  multiply and divide passes, one bit or digit per cycle; a point inside
//  stops after the first multiply pass.
//  One item is in work at a time; the result register lets the next item in
//  while a result waits. Reset (synchronous) clears sphere and start values.
// ----------------------------------------------------------------------------
module bounding_sphere_grow_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bsg_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bsg_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [bsg_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [bsg_pkg::CoordWidth-1:0]       csr_wdata
);

   localparam int CW = bsg_pkg::CoordWidth;
   localparam int RW = bsg_pkg::RadWidth;
   localparam int DW = bsg_pkg::DiffWidth;
   localparam int MW = bsg_pkg::MulWidth;
   localparam int PW = bsg_pkg::ProdWidth;
   localparam int SW = bsg_pkg::SqWidth;
   localparam int TW = bsg_pkg::RootWidth;
   localparam int QW = bsg_pkg::QuoWidth;

   bsg_pkg::state_type                   state_ff, state_in;

   logic [CW-1:0]                        start_cx_ff, start_cy_ff, start_cz_ff;
   logic [RW-1:0]                        start_r_ff;
   logic [CW-1:0]                        cx_ff, cy_ff, cz_ff;
   logic [RW-1:0]                        r_ff;
   logic [CW-1:0]                        px_ff, py_ff, pz_ff;
   logic [DW-1:0]                        mx_ff, my_ff, mz_ff;
   logic                                 sx_ff, sy_ff, sz_ff;
   logic [SW-1:0]                        s_ff;
   logic [TW-1:0]                        d_ff;
   logic                                 grew_ff;
   logic                                 rsp_valid_ff;
   bsg_pkg::rsp_type                     rsp_ff;

   logic [DW-1:0]                        dx, dy, dz;
   logic                                 mul_start, root_start, div_start;
   logic                                 mul_phase2;
   logic                                 rsp_load;
   logic [MW-1:0]                        num;
   logic [MW-1:0]                        bx, by, bz;
   logic [PW-1:0]                        px_prod, py_prod, pz_prod, rr_prod;
   logic                                 mx_done, my_done, mz_done, rr_done;
   logic                                 root_done;
   logic [TW-1:0]                        root;
   logic [QW-1:0]                        qx, qy, qz;
   logic                                 qx_done, qy_done, qz_done;
   logic [MW-1:0]                        den;
   logic [TW:0]                          rsum;
   logic [TW-1:0]                        rhalf;
   logic [RW-1:0]                        r_next;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_cx_ff <= '0;
         start_cy_ff <= '0;
         start_cz_ff <= '0;
         start_r_ff  <= '0;
      end else if (csr_we) begin
         unique case (bsg_pkg::csr_idx_type'(csr_index))
            bsg_pkg::CSR_CENTER_X: start_cx_ff <= csr_wdata;
            bsg_pkg::CSR_CENTER_Y: start_cy_ff <= csr_wdata;
            bsg_pkg::CSR_CENTER_Z: start_cz_ff <= csr_wdata;
            bsg_pkg::CSR_RADIUS:   start_r_ff  <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // exact differences point - center
   assign dx = {px_ff[CW-1], px_ff} - {cx_ff[CW-1], cx_ff};
   assign dy = {py_ff[CW-1], py_ff} - {cy_ff[CW-1], cy_ff};
   assign dz = {pz_ff[CW-1], pz_ff} - {cz_ff[CW-1], cz_ff};

   // multiplier operands: squares first, then |diff| * (d - r)
   assign num = MW'(d_ff) - MW'(r_ff);
   assign bx  = mul_phase2 ? num : MW'(mx_ff);
   assign by  = mul_phase2 ? num : MW'(my_ff);
   assign bz  = mul_phase2 ? num : MW'(mz_ff);
   assign den = {1'b0, d_ff} << 1;

   // new radius (r + d) / 2, saturated
   assign rsum   = (TW + 1)'(d_ff) + (TW + 1)'(r_ff);
   assign rhalf  = rsum[TW:1];
   assign r_next = (rhalf > TW'(bsg_pkg::RadMax)) ? bsg_pkg::RadMax : rhalf[RW-1:0];

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and unit starts
   always_comb begin
      state_in   = state_ff;
      mul_start  = 1'b0;
      mul_phase2 = 1'b0;
      root_start = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         bsg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) state_in = bsg_pkg::ST_DIFF;
         end
         bsg_pkg::ST_DIFF:  state_in = bsg_pkg::ST_SQ_GO;
         bsg_pkg::ST_SQ_GO: begin
            mul_start = 1'b1;
            state_in  = bsg_pkg::ST_SQ;
         end
         bsg_pkg::ST_SQ: begin
            if (mx_done && my_done && mz_done && rr_done) state_in = bsg_pkg::ST_SUM1;
         end
         bsg_pkg::ST_SUM1: state_in = bsg_pkg::ST_SUM2;
         bsg_pkg::ST_SUM2: state_in = bsg_pkg::ST_CMP;
         bsg_pkg::ST_CMP: begin
            if (s_ff > rr_prod[SW-1:0]) state_in = bsg_pkg::ST_ROOT_GO;
            else                        state_in = bsg_pkg::ST_OUT;
         end
         bsg_pkg::ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = bsg_pkg::ST_ROOT;
         end
         bsg_pkg::ST_ROOT: begin
            if (root_done) state_in = bsg_pkg::ST_MUL_GO;
         end
         bsg_pkg::ST_MUL_GO: begin
            mul_start  = 1'b1;
            mul_phase2 = 1'b1;
            state_in   = bsg_pkg::ST_MUL;
         end
         bsg_pkg::ST_MUL: begin
            if (mx_done && my_done && mz_done) state_in = bsg_pkg::ST_DIV_GO;
         end
         bsg_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = bsg_pkg::ST_DIV;
         end
         bsg_pkg::ST_DIV: begin
            if (qx_done && qy_done && qz_done) state_in = bsg_pkg::ST_UPD;
         end
         bsg_pkg::ST_UPD: state_in = bsg_pkg::ST_OUT;
         bsg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = bsg_pkg::ST_IDLE;
            end
         end
         default: state_in = bsg_pkg::ST_IDLE;
      endcase
   end

   // sphere state (control, cleared by reset)
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         r_ff  <= '0;
      end else if (state_ff == bsg_pkg::ST_IDLE && req_valid && req_data.restart) begin
         cx_ff <= start_cx_ff;
         cy_ff <= start_cy_ff;
         cz_ff <= start_cz_ff;
         r_ff  <= start_r_ff;
      end else if (state_ff == bsg_pkg::ST_UPD) begin
         cx_ff <= sx_ff ? cx_ff - qx : cx_ff + qx;
         cy_ff <= sy_ff ? cy_ff - qy : cy_ff + qy;
         cz_ff <= sz_ff ? cz_ff - qz : cz_ff + qz;
         r_ff  <= r_next;
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         bsg_pkg::ST_IDLE: begin
            px_ff <= req_data.point_x;
            py_ff <= req_data.point_y;
            pz_ff <= req_data.point_z;
         end
         bsg_pkg::ST_DIFF: begin
            sx_ff <= dx[DW-1];
            sy_ff <= dy[DW-1];
            sz_ff <= dz[DW-1];
            mx_ff <= dx[DW-1] ? DW'(-dx) : dx;
            my_ff <= dy[DW-1] ? DW'(-dy) : dy;
            mz_ff <= dz[DW-1] ? DW'(-dz) : dz;
         end
         bsg_pkg::ST_SUM1: s_ff <= px_prod[SW-1:0] + py_prod[SW-1:0];
         bsg_pkg::ST_SUM2: s_ff <= s_ff + pz_prod[SW-1:0];
         bsg_pkg::ST_CMP:  grew_ff <= (s_ff > rr_prod[SW-1:0]);
         bsg_pkg::ST_ROOT: begin
            if (root_done) d_ff <= root;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.center_x_out <= cx_ff;
         rsp_ff.center_y_out <= cy_ff;
         rsp_ff.center_z_out <= cz_ff;
         rsp_ff.radius_out   <= r_ff;
         rsp_ff.grew         <= grew_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // serial units
   bsg_mul u_mul_x (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(MW'(mx_ff)), .mplier(bx), .done(mx_done), .prod(px_prod)
   );
   bsg_mul u_mul_y (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(MW'(my_ff)), .mplier(by), .done(my_done), .prod(py_prod)
   );
   bsg_mul u_mul_z (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(MW'(mz_ff)), .mplier(bz), .done(mz_done), .prod(pz_prod)
   );
   bsg_mul u_mul_r (
      .clock(clock), .reset(reset), .start(mul_start && !mul_phase2),
      .mcand(MW'(r_ff)), .mplier(MW'(r_ff)), .done(rr_done), .prod(rr_prod)
   );

   bsg_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(root_start),
      .radicand(s_ff), .done(root_done), .root(root)
   );

   bsg_div u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(px_prod), .divisor(den), .done(qx_done), .quot(qx)
   );
   bsg_div u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(py_prod), .divisor(den), .done(qy_done), .quot(qy)
   );
   bsg_div u_div_z (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(pz_prod), .divisor(den), .done(qz_done), .quot(qz)
   );

   // checks
   a_accept_to_diff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsg_pkg::ST_IDLE && req_valid) |=> (state_ff == bsg_pkg::ST_DIFF))
      else $error("accepted item did not start");

   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      (mx_done == my_done) && (my_done == mz_done))
      else $error("multiplier lanes out of step");

   a_root_covers_radius: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsg_pkg::ST_UPD) |-> (TW'(r_ff) <= d_ff))
      else $error("root below radius on grow");

   a_radius_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsg_pkg::ST_UPD) |=> (r_ff >= $past(r_ff)))
      else $error("radius shrank on grow");

endmodule
